// ===== design/rrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrc_pkg - shared types and constants for the read range coalescer
// Item and result layouts, configuration block, status codes, register map.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int OBJ_W   = 32;
  localparam int OFF_W   = 64;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 544;
  localparam int OUT_USER_W = 3;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_LIM = 2'd3;

  localparam logic [OFF_W-1:0] MAX_GAP_RST  = 64'd0;
  localparam logic [OFF_W-1:0] MAX_SPAN_RST = 64'd1048576;
  localparam logic [CNT_W-1:0] SPAN_LIM_RST = 32'd1024;
  localparam logic [CNT_W-1:0] COPY_LIM_RST = 32'd1024;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_ALLOC   = 2'd2
  } status_t;

  typedef struct packed {
    logic [OFF_W-1:0] max_gap_bytes;
    logic [OFF_W-1:0] max_span_bytes;
    logic [CNT_W-1:0] span_limit;
    logic [CNT_W-1:0] copy_limit;
  } cfg_t;

  typedef struct packed {
    logic [OBJ_W-1:0] object_id;
    logic             object_valid;
    logic [OFF_W-1:0] range_offset;
    logic [OFF_W-1:0] length_bytes;
    logic [OFF_W-1:0] dest_offset;
    logic             last_range;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] span_index;
    logic             new_span;
    logic [OFF_W-1:0] span_offset;
    logic [OFF_W-1:0] span_length;
    logic [OFF_W-1:0] span_staging_offset;
    logic [OFF_W-1:0] copy_source_offset;
    logic [OFF_W-1:0] copy_destination;
    logic [OFF_W-1:0] copy_length;
    logic [OFF_W-1:0] staging_total;
    logic [OFF_W-1:0] requested_total;
    logic             plan_done;
  } result_t;

endpackage

// ===== design/rrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rrc_cfg_regs - configuration register bank
// Write-only registers, indexed; each index selects one of the four registers.
// ----------------------------------------------------------------------------
module rrc_cfg_regs import rrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_gap_bytes  <= MAX_GAP_RST;
      cfg_r.max_span_bytes <= MAX_SPAN_RST;
      cfg_r.span_limit     <= SPAN_LIM_RST;
      cfg_r.copy_limit     <= COPY_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_GAP:  cfg_r.max_gap_bytes  <= cfg_wdata;
        CFG_MAX_SPAN: cfg_r.max_span_bytes <= cfg_wdata;
        CFG_SPAN_LIM: cfg_r.span_limit     <= cfg_wdata[CNT_W-1:0];
        CFG_COPY_LIM: cfg_r.copy_limit     <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/rrc_in_stage.sv =====
// ----------------------------------------------------------------------------
// rrc_in_stage - input register
// Unpacks the stream item and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module rrc_in_stage import rrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tlast,
  input  logic                  advance,
  output in_item_t              item,
  output logic                  item_valid
);

  in_item_t item_r;
  logic     valid_r;
  logic     take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.object_id    <= in_tdata[31:0];
      item_r.object_valid <= in_tuser[0];
      item_r.range_offset <= in_tdata[95:32];
      item_r.length_bytes <= in_tdata[159:96];
      item_r.dest_offset  <= in_tdata[223:160];
      item_r.last_range   <= in_tlast;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

// ===== design/rrc_plan_core.sv =====
// ----------------------------------------------------------------------------
// rrc_plan_core - span merge decision and plan state
// Checks one range against the open span, forms its result and updates
// the plan state in the same cycle.
// ----------------------------------------------------------------------------
module rrc_plan_core import rrc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  in_item_t item,
  input  logic     step,
  output result_t  res
);

  logic [OBJ_W-1:0] open_object_r,     open_object_nxt;
  logic [CNT_W-1:0] span_count_r,      span_count_nxt;
  logic [OFF_W-1:0] open_span_start_r, open_span_start_nxt;
  logic [OFF_W-1:0] open_span_len_r,   open_span_len_nxt;
  logic [OFF_W-1:0] open_span_stg_r,   open_span_stg_nxt;
  logic [OFF_W-1:0] staging_used_r,    staging_used_nxt;
  logic [OFF_W-1:0] requested_sum_r,   requested_sum_nxt;
  logic [CNT_W-1:0] item_count_r,      item_count_nxt;
  status_t          error_code_r,      error_code_nxt;

  logic [OFF_W:0]   off_end;
  logic [OFF_W:0]   req_sum;
  logic [OFF_W:0]   stg_new;
  logic [OFF_W:0]   stg_merge;
  logic [OFF_W-1:0] prev_end;
  logic [OFF_W-1:0] gap;
  logic [OFF_W-1:0] combined;
  logic             bad_input;
  logic             can_merge;
  logic             merged;
  logic             bad_merge;
  logic             no_alloc;
  status_t          status;

  always_comb begin
    off_end   = {1'b0, item.range_offset} + {1'b0, item.length_bytes};
    req_sum   = {1'b0, requested_sum_r} + {1'b0, item.length_bytes};
    stg_new   = {1'b0, staging_used_r} + {1'b0, item.length_bytes};
    bad_input = (cfg.max_span_bytes == '0) || (item_count_r >= cfg.copy_limit) ||
                !item.object_valid || (item.length_bytes == '0) ||
                off_end[OFF_W] || req_sum[OFF_W];

    prev_end  = open_span_start_r + open_span_len_r;
    gap       = (item.range_offset > prev_end) ? item.range_offset - prev_end : '0;
    combined  = (off_end[OFF_W-1:0] > prev_end) ?
                off_end[OFF_W-1:0] - open_span_start_r : open_span_len_r;
    can_merge = (span_count_r != '0) && (item.object_id == open_object_r) &&
                (item.range_offset >= open_span_start_r) &&
                (gap <= cfg.max_gap_bytes) && (combined <= cfg.max_span_bytes);
    stg_merge = {1'b0, open_span_stg_r} + {1'b0, combined};
    bad_merge = can_merge && stg_merge[OFF_W];
    merged    = can_merge;
    no_alloc  = !merged && ((span_count_r == cfg.span_limit) ||
                (item.length_bytes > cfg.max_span_bytes) || stg_new[OFF_W]);

    priority if (error_code_r != ST_OK) status = error_code_r;
    else if (bad_input || bad_merge)    status = ST_INVALID;
    else if (no_alloc)                  status = ST_ALLOC;
    else                                status = ST_OK;
  end

  // next plan state and result
  always_comb begin
    open_object_nxt     = open_object_r;
    span_count_nxt      = span_count_r;
    open_span_start_nxt = open_span_start_r;
    open_span_len_nxt   = open_span_len_r;
    open_span_stg_nxt   = open_span_stg_r;
    staging_used_nxt    = staging_used_r;
    requested_sum_nxt   = requested_sum_r;
    item_count_nxt      = item_count_r;
    error_code_nxt      = status;

    if (status == ST_OK) begin
      if (merged) begin
        open_span_len_nxt   = combined;
      end else begin
        open_object_nxt     = item.object_id;
        open_span_start_nxt = item.range_offset;
        open_span_len_nxt   = item.length_bytes;
        open_span_stg_nxt   = staging_used_r;
        span_count_nxt      = span_count_r + 1'b1;
      end
      requested_sum_nxt = req_sum[OFF_W-1:0];
      item_count_nxt    = item_count_r + 1'b1;
      staging_used_nxt  = open_span_stg_nxt + open_span_len_nxt;
    end

    res = '0;
    res.status    = status;
    res.plan_done = item.last_range;
    if (status == ST_OK) begin
      res.span_index          = span_count_nxt - 1'b1;
      res.new_span            = !merged;
      res.span_offset         = open_span_start_nxt;
      res.span_length         = open_span_len_nxt;
      res.span_staging_offset = open_span_stg_nxt;
      res.copy_source_offset  = item.range_offset - open_span_start_nxt;
      res.copy_destination    = item.dest_offset;
      res.copy_length         = item.length_bytes;
      res.staging_total       = staging_used_nxt;
      res.requested_total     = requested_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_range)) begin
      open_object_r     <= '0;
      span_count_r      <= '0;
      open_span_start_r <= '0;
      open_span_len_r   <= '0;
      open_span_stg_r   <= '0;
      staging_used_r    <= '0;
      requested_sum_r   <= '0;
      item_count_r      <= '0;
      error_code_r      <= ST_OK;
    end else if (step) begin
      open_object_r     <= open_object_nxt;
      span_count_r      <= span_count_nxt;
      open_span_start_r <= open_span_start_nxt;
      open_span_len_r   <= open_span_len_nxt;
      open_span_stg_r   <= open_span_stg_nxt;
      staging_used_r    <= staging_used_nxt;
      requested_sum_r   <= requested_sum_nxt;
      item_count_r      <= item_count_nxt;
      error_code_r      <= error_code_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.status != ST_OK) |-> (res.span_length == '0 && res.requested_total == '0))
    else $error("error result carries payload");

  a_plan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last_range) |=> (span_count_r == '0 && error_code_r == ST_OK &&
                                   item_count_r == '0))
    else $error("plan state not cleared after last item");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.last_range && error_code_r != ST_OK) |=>
      (error_code_r == $past(error_code_r) && span_count_r == $past(span_count_r)))
    else $error("sticky error changed or state moved");

  a_new_span: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.last_range && res.status == ST_OK && res.new_span) |=>
      (span_count_r == $past(span_count_r) + 1'b1))
    else $error("new span did not bump span count");
`endif

endmodule

// ===== design/read_range_coalescer.sv =====
// ----------------------------------------------------------------------------
// read_range_coalescer - merges object read ranges into staging spans
//
// in_*  : one read range per item. tdata holds object_id, range_offset,
//         length_bytes, dest_offset; tuser holds object_valid;
//         tlast marks the final range of a plan.
// out_* : one result per item, in order. tuser holds status and new_span,
//         tlast is plan_done; tdata carries the span, copy entry and totals.
// cfg_* : write-only registers (max_gap_bytes, max_span_bytes, span_limit,
//         copy_limit); the user must write them only while no item is in
//         flight; the block itself does not enforce this.
// An item waits in the input register, its result in the output register,
// before it shows on out_*. Throughput: one item per cycle while out_tready
// is high; compare, merge and running sums are combinational in the core.
// Reset clears the plan state and loads register defaults; no sweep needed.
// When out_tready is low the result is held and one further item waits in
// the input register; in_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module read_range_coalescer import rrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // object_id[31:0], range_offset[95:32], length_bytes[159:96],
  // dest_offset[223:160]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // object_valid[0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // span_index[31:0], span_offset[95:32], span_length[159:96],
  // span_staging_offset[223:160], copy_source_offset[287:224],
  // copy_destination[351:288], copy_length[415:352],
  // staging_total[479:416], requested_total[543:480]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0], new_span[2]
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  result_t  res;
  result_t  out_r;
  logic     out_valid_r;

  assign advance = item_valid && (!out_valid_r || out_tready);

  rrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rrc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  rrc_plan_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item),
    .step  (advance),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.plan_done;
  assign out_tuser  = {out_r.new_span, out_r.status};
  assign out_tdata  = {out_r.requested_total, out_r.staging_total, out_r.copy_length,
                       out_r.copy_destination, out_r.copy_source_offset,
                       out_r.span_staging_offset, out_r.span_length,
                       out_r.span_offset, out_r.span_index};

endmodule
